// ===== rtl/ptu_pkg.sv =====
// shared types, widths and constants for the precision-time system clock
// no dependencies; imported by every rtl module of the block
`default_nettype none

package ptu_pkg;

  // field widths
  localparam int unsigned ActW   = 3;
  localparam int unsigned SecW   = 32;
  localparam int unsigned InNsW  = 31;
  localparam int unsigned RateW  = 32;
  localparam int unsigned SubW   = 31;
  localparam int unsigned NsW    = 30;
  localparam int unsigned AddW   = 32;
  localparam int unsigned IncW   = 8;
  localparam int unsigned AdjW   = 24;
  localparam int unsigned T1W    = 24;
  localparam int unsigned T2W    = 26;
  localparam int unsigned CfgIdxW  = 2;
  localparam int unsigned CfgDataW = 32;

  // stream packing
  localparam int unsigned InTdataW  = 96;
  localparam int unsigned OutTdataW = 96;

  // constants of the time arithmetic
  localparam logic [SubW-1:0]         SubMax         = '1;
  localparam logic [NsW-1:0]          NsPerSec       = 30'd1000000000;
  localparam logic signed [RateW-1:0] RateLimit      = 32'sd5120000;
  localparam logic [8:0]              RateGain       = 9'd275;
  localparam logic [AddW-1:0]         ResetAddend    = 32'h35455A81;
  localparam logic [IncW-1:0]         ResetIncrement = 8'd43;

  // subsecond converter: |ns| * 2^31 / 1e9 = |ns| * 2^22 / 5^9
  // reciprocal estimate is low by at most one, fixed by one compare step
  localparam int unsigned       RecipW       = 32;
  localparam int unsigned       RecipShift   = 30;
  localparam logic [RecipW-1:0] SubRecip     = 32'd2305843009;  // floor(2^61 / 1e9)
  localparam int unsigned       NsScaleShift = 22;
  localparam int unsigned       FixW         = NsW + NsScaleShift;
  localparam logic [20:0]       NsPerSecOdd  = 21'd1953125;     // 1e9 / 2^9

  typedef enum logic [ActW-1:0] {
    ACT_TICK   = 3'd0,
    ACT_READ   = 3'd1,
    ACT_SET    = 3'd2,
    ACT_OFFSET = 3'd3,
    ACT_RATE   = 3'd4
  } action_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_INCREMENT = 2'd0,
    CFG_FINE_MODE = 2'd1,
    CFG_BASE      = 2'd2
  } cfg_reg_e;

  // what the controller needs to know about an arriving item
  typedef enum logic [1:0] {
    KIND_PLAIN   = 2'd0,
    KIND_CONVERT = 2'd1,
    KIND_RATE    = 2'd2
  } item_kind_e;

  typedef struct packed {
    logic load;
    logic sub_mul;
    logic sub_fix;
    logic rate_mul;
    logic rate_scale;
    logic apply;
    logic conv;
    logic emit;
  } ptu_cmd_t;

  typedef struct packed {
    item_kind_e in_kind;
    logic       out_free;
  } ptu_status_t;

endpackage

`default_nettype wire

// ===== rtl/ptp_system_time_unit.sv =====
// Precision-time system clock: 32-bit seconds and 31-bit binary subseconds (2^-31 s).
// Every input item returns one item with the time after it and the addend in use.
// A tick or read item runs the apply, convert and emit states. An adjust-rate item
// first runs rate-multiply and rate-scale (two registered multiplies). A set-time or
// add-offset item first runs the ns-to-subsecond conversion, a reciprocal multiply
// followed by a one-step correction. The result sits in an output register, so a new
// item is accepted while the previous result waits on m_axis_tready. Configuration
// writes are taken at any time and should be made while the block is idle.
// depends on ptu_pkg, ptu_ctrl, ptu_datapath
`default_nettype none

module ptp_system_time_unit
  import ptu_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  // input items
  input  wire logic                 s_axis_tvalid,
  output logic                      s_axis_tready,
  // [31:0] time_seconds, [62:32] time_nanoseconds, [94:63] rate_adjust, [95] zero
  input  wire logic [InTdataW-1:0]  s_axis_tdata,
  // [2:0] action
  input  wire logic [ActW-1:0]      s_axis_tuser,
  // result items
  output logic                      m_axis_tvalid,
  input  wire logic                 m_axis_tready,
  // [31:0] now_seconds, [61:32] now_nanoseconds, [93:62] addend_in_use, [95:94] zero
  output logic [OutTdataW-1:0]      m_axis_tdata,
  // configuration writes
  input  wire logic                 cfg_valid_i,
  output logic                      cfg_ready_o,
  input  wire logic [CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [CfgDataW-1:0]  cfg_data_i
);

  ptu_cmd_t    cmd;
  ptu_status_t status;

  logic [SecW-1:0] out_seconds;
  logic [NsW-1:0]  out_ns;
  logic [AddW-1:0] out_addend;

  assign cfg_ready_o = 1'b1;

  // sequencing
  ptu_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // arithmetic and storage
  ptu_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .status_o      (status),
    .in_action_i   (s_axis_tuser),
    .in_seconds_i  (s_axis_tdata[SecW-1:0]),
    .in_ns_i       (s_axis_tdata[SecW+InNsW-1:SecW]),
    .in_rate_i     (s_axis_tdata[SecW+InNsW+RateW-1:SecW+InNsW]),
    .cfg_we_i      (cfg_valid_i & cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .out_ready_i   (m_axis_tready),
    .out_valid_o   (m_axis_tvalid),
    .out_seconds_o (out_seconds),
    .out_ns_o      (out_ns),
    .out_addend_o  (out_addend)
  );

  // result packing
  assign m_axis_tdata = {{(OutTdataW-SecW-NsW-AddW){1'b0}}, out_addend, out_ns, out_seconds};

`ifndef NO_ASSERTIONS
  // reported nanoseconds always stay below one second
  a_ns_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[SecW+NsW-1:SecW] < NsPerSec))
    else $error("nanoseconds of a result item reach one second");

  // an accepted item keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("block accepts a second item right after the first");

  // a result appears only as the controller returns to idle
  a_emit_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> s_axis_tready)
    else $error("result item emitted while the controller is still busy");
`endif

endmodule

`default_nettype wire

// ===== rtl/ptu_ctrl.sv =====
// sequencing state machine of the precision-time system clock
// depends on ptu_pkg; drives ptu_datapath through command and status structs
`default_nettype none

module ptu_ctrl
  import ptu_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire ptu_status_t status_i,
  output ptu_cmd_t         cmd_o
);

  typedef enum logic [7:0] {
    S_IDLE       = 8'b00000001,
    S_SUB_MUL    = 8'b00000010,
    S_SUB_FIX    = 8'b00000100,
    S_RATE_MUL   = 8'b00001000,
    S_RATE_SCALE = 8'b00010000,
    S_APPLY      = 8'b00100000,
    S_CONV       = 8'b01000000,
    S_EMIT       = 8'b10000000
  } state_e;

  state_e state_q, state_d;

  assign in_ready_o = (state_q == S_IDLE);

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          unique case (status_i.in_kind)
            KIND_CONVERT: state_d = S_SUB_MUL;
            KIND_RATE:    state_d = S_RATE_MUL;
            default:      state_d = S_APPLY;
          endcase
        end
      end
      S_SUB_MUL: begin
        cmd_o.sub_mul = 1'b1;
        state_d       = S_SUB_FIX;
      end
      S_SUB_FIX: begin
        cmd_o.sub_fix = 1'b1;
        state_d       = S_APPLY;
      end
      S_RATE_MUL: begin
        cmd_o.rate_mul = 1'b1;
        state_d        = S_RATE_SCALE;
      end
      S_RATE_SCALE: begin
        cmd_o.rate_scale = 1'b1;
        state_d          = S_APPLY;
      end
      S_APPLY: begin
        cmd_o.apply = 1'b1;
        state_d     = S_CONV;
      end
      S_CONV: begin
        cmd_o.conv = 1'b1;
        state_d    = S_EMIT;
      end
      S_EMIT: begin
        if (status_i.out_free) begin
          cmd_o.emit = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/ptu_datapath.sv =====
// time registers, configuration, subsecond converter, rate multipliers, output register
// depends on ptu_pkg; sequenced by ptu_ctrl through ptu_cmd_t
`default_nettype none

module ptu_datapath
  import ptu_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire ptu_cmd_t            cmd_i,
  output ptu_status_t              status_o,
  input  wire logic [ActW-1:0]     in_action_i,
  input  wire logic [SecW-1:0]     in_seconds_i,
  input  wire logic [InNsW-1:0]    in_ns_i,
  input  wire logic [RateW-1:0]    in_rate_i,
  input  wire logic                cfg_we_i,
  input  wire logic [CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [CfgDataW-1:0] cfg_data_i,
  input  wire logic                out_ready_i,
  output logic                     out_valid_o,
  output logic [SecW-1:0]          out_seconds_o,
  output logic [NsW-1:0]           out_ns_o,
  output logic [AddW-1:0]          out_addend_o
);

  // configuration
  logic [IncW-1:0] inc_q;
  logic            fine_q;
  logic [AddW-1:0] base_q;

  // clock state
  logic [SecW-1:0] sec_q, sec_d;
  logic [SubW-1:0] sub_q, sub_d;
  logic [AddW-1:0] acc_q, acc_d;
  logic [AddW-1:0] addend_q, addend_d;

  // item registers
  logic [ActW-1:0]        act_q;
  logic                   neg_q;
  logic [SecW-1:0]        sec_mag_q;
  logic                   sat_q;
  logic [NsW-1:0]         ns_mag_q;
  logic [SubW-1:0]        quo_q;
  logic signed [AdjW-1:0] adj_q;
  logic signed [T1W-1:0]  t1_q;
  logic signed [T2W-1:0]  t2_q;
  logic [NsW-1:0]         ns_q;
  logic                   out_valid_q;

  // sign and magnitude of the offered time
  logic                   in_negative;
  logic [SecW-1:0]        in_sec_mag;
  logic [InNsW-1:0]       in_ns_mag;
  logic                   in_sat;
  logic signed [RateW-1:0] in_rate_s;
  logic signed [AdjW-1:0]  in_adj;
  item_kind_e              in_kind;

  assign in_negative = in_seconds_i[SecW-1]
                     | ((in_seconds_i == '0) & in_ns_i[InNsW-1]);
  assign in_sec_mag  = in_negative ? (~in_seconds_i + 1'b1) : in_seconds_i;
  assign in_ns_mag   = in_ns_i[InNsW-1] ? (~in_ns_i + 1'b1) : in_ns_i;
  assign in_sat      = in_ns_mag >= {1'b0, NsPerSec};
  assign in_rate_s   = $signed(in_rate_i);

  // clamp the rate correction
  always_comb begin
    priority if (in_rate_s > RateLimit) begin
      in_adj = RateLimit[AdjW-1:0];
    end else if (in_rate_s < -RateLimit) begin
      in_adj = AdjW'(-RateLimit);
    end else begin
      in_adj = in_rate_s[AdjW-1:0];
    end
  end

  // item kind for the controller
  always_comb begin
    unique case (in_action_i)
      ACT_SET, ACT_OFFSET: in_kind = KIND_CONVERT;
      ACT_RATE:            in_kind = KIND_RATE;
      default:             in_kind = KIND_PLAIN;
    endcase
  end

  assign status_o = '{in_kind: in_kind, out_free: ~out_valid_q | out_ready_i};

  // nanoseconds to subseconds: reciprocal estimate, then add one if the
  // remainder still holds a whole divisor
  logic [NsW+RecipW-1:0] recip_prod;
  logic [FixW-1:0]       fix_prod;
  logic [FixW-1:0]       fix_rem;
  logic                  fix_up;

  assign recip_prod = (NsW+RecipW)'(ns_mag_q) * (NsW+RecipW)'(SubRecip);
  assign fix_prod   = FixW'(quo_q) * FixW'(NsPerSecOdd);
  assign fix_rem    = {ns_mag_q, {NsScaleShift{1'b0}}} - fix_prod;
  assign fix_up     = fix_rem >= FixW'(NsPerSecOdd);

  // rate multiplications, one per step
  logic signed [AdjW+9:0] rate_prod;
  logic signed [T1W+8:0]  scale_prod;

  assign rate_prod  = adj_q * $signed({1'b0, RateGain});
  assign scale_prod = t1_q * $signed({1'b0, base_q[AddW-1:AddW-8]});

  // subseconds to nanoseconds
  logic [SubW+NsW-1:0] ns_prod;

  assign ns_prod = (SubW+NsW)'(sub_q) * (SubW+NsW)'(NsPerSec);

  // state update
  logic [SubW-1:0] sub_res;
  logic [AddW:0]   acc_sum;
  logic            tick_count;
  logic [SubW:0]   sub_inc;
  logic [SubW:0]   sub_add;
  logic [SubW:0]   sub_sub;

  assign sub_res    = sat_q ? SubMax : quo_q;
  assign acc_sum    = {1'b0, acc_q} + {1'b0, addend_q};
  assign tick_count = ~fine_q | acc_sum[AddW];
  assign sub_inc    = {1'b0, sub_q} + (SubW+1)'(inc_q);
  assign sub_add    = {1'b0, sub_q} + {1'b0, sub_res};
  assign sub_sub    = {1'b0, sub_q} - {1'b0, sub_res};

  always_comb begin
    sec_d    = sec_q;
    sub_d    = sub_q;
    acc_d    = acc_q;
    addend_d = addend_q;
    unique case (act_q)
      ACT_TICK: begin
        if (fine_q) begin
          acc_d = acc_sum[AddW-1:0];
        end
        if (tick_count) begin
          sub_d = sub_inc[SubW-1:0];
          sec_d = sec_q + SecW'(sub_inc[SubW]);
        end
      end
      ACT_SET: begin
        sec_d = sec_mag_q;
        sub_d = sub_res;
      end
      ACT_OFFSET: begin
        if (!neg_q) begin
          sub_d = sub_add[SubW-1:0];
          sec_d = sec_q + sec_mag_q + SecW'(sub_add[SubW]);
        end else begin
          sub_d = sub_sub[SubW-1:0];
          sec_d = sec_q - sec_mag_q - SecW'(sub_sub[SubW]);
        end
      end
      ACT_RATE: begin
        addend_d = base_q + {{(AddW-T2W){t2_q[T2W-1]}}, t2_q};
      end
      default: ;
    endcase
  end

  // configuration and clock state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inc_q    <= ResetIncrement;
      fine_q   <= 1'b1;
      base_q   <= ResetAddend;
      sec_q    <= '0;
      sub_q    <= '0;
      acc_q    <= '0;
      addend_q <= ResetAddend;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          CFG_INCREMENT: inc_q  <= cfg_data_i[IncW-1:0];
          CFG_FINE_MODE: fine_q <= cfg_data_i[0];
          CFG_BASE:      base_q <= cfg_data_i[AddW-1:0];
          default: ;
        endcase
      end
      if (cmd_i.apply) begin
        sec_q    <= sec_d;
        sub_q    <= sub_d;
        acc_q    <= acc_d;
        addend_q <= addend_d;
      end
    end
  end

  // item working registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      act_q     <= in_action_i;
      neg_q     <= in_negative;
      sec_mag_q <= in_sec_mag;
      sat_q     <= in_sat;
      ns_mag_q  <= in_ns_mag[NsW-1:0];
      adj_q     <= in_adj;
    end
    if (cmd_i.sub_mul) begin
      quo_q <= recip_prod[RecipShift+SubW-1:RecipShift];
    end
    if (cmd_i.sub_fix && fix_up) begin
      quo_q <= quo_q + 1'b1;
    end
    if (cmd_i.rate_mul) begin
      t1_q <= rate_prod[T1W+7:8];
    end
    if (cmd_i.rate_scale) begin
      t2_q <= scale_prod[T2W+5:6];
    end
    if (cmd_i.conv) begin
      ns_q <= ns_prod[SubW+NsW-1:SubW];
    end
    if (cmd_i.emit) begin
      out_seconds_o <= sec_q;
      out_ns_o      <= ns_q;
      out_addend_o  <= addend_q;
    end
  end

  // output item valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire
